[design/triangle_unit_normal_defines.svh]
// -----------------------------------------------------------------------------
// triangle_unit_normal_defines
// Assertion macros of the unit normal pipeline.
// -----------------------------------------------------------------------------
`ifndef TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_DEFINES_SVH

`ifndef SYNTHESIS
`define TUN_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("triangle_unit_normal: check failed");
`define TUN_ASSERT_NEVER(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("triangle_unit_normal: forbidden condition");
`else
`define TUN_ASSERT(name, prop)
`define TUN_ASSERT_NEVER(name, cond)
`endif

`endif

[design/tun_pkg.sv]
// -----------------------------------------------------------------------------
// tun_pkg
// Shared constants and types of the unit normal pipeline.
// -----------------------------------------------------------------------------
package tun_pkg;

    // largest normalized magnitude lies in [2^(NORM_TOP-1), 2^NORM_TOP)
    localparam int NORM_TOP  = 30;
    localparam int ROOT_BITS = NORM_TOP + 1;
    localparam int SUM_BITS  = 2 * ROOT_BITS;

    typedef logic [NORM_TOP-1:0] umag_t;

    // sign of each component and zero-normal flag, carried along the pipe
    typedef struct packed {
        logic [2:0] neg;
        logic       deg;
    } sgn_t;

endpackage

[design/tun_cross.sv]
// -----------------------------------------------------------------------------
// tun_cross
// Edge vectors, six partial products and the cross product, three stages.
// -----------------------------------------------------------------------------
module tun_cross #(
    parameter int COORD_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_vld,
    input  logic [9*COORD_BITS-1:0]     pts,
    output logic                        out_vld,
    output logic signed [2*COORD_BITS+2:0] n_x,
    output logic signed [2*COORD_BITS+2:0] n_y,
    output logic signed [2*COORD_BITS+2:0] n_z
);

    localparam int EW = COORD_BITS + 1;
    localparam int PW = 2 * EW;
    localparam int CW = PW + 1;

    logic signed [COORD_BITS-1:0] p [9];
    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e2_reg [3];
    logic signed [PW-1:0] prod_reg [6];
    logic signed [CW-1:0] cross_reg [3];
    logic [2:0] vld_reg;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            p[i] = pts[i*COORD_BITS +: COORD_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[1:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i] <= EW'(p[3+i]) - EW'(p[i]);
                e2_reg[i] <= EW'(p[6+i]) - EW'(p[i]);
            end
            prod_reg[0] <= e1_reg[1] * e2_reg[2];
            prod_reg[1] <= e1_reg[2] * e2_reg[1];
            prod_reg[2] <= e1_reg[2] * e2_reg[0];
            prod_reg[3] <= e1_reg[0] * e2_reg[2];
            prod_reg[4] <= e1_reg[0] * e2_reg[1];
            prod_reg[5] <= e1_reg[1] * e2_reg[0];
            for (int i = 0; i < 3; i++)
            begin
                cross_reg[i] <= CW'(prod_reg[2*i]) - CW'(prod_reg[2*i+1]);
            end
        end
    end

    assign out_vld = vld_reg[2];
    assign n_x     = cross_reg[0];
    assign n_y     = cross_reg[1];
    assign n_z     = cross_reg[2];

endmodule

[design/tun_scale.sv]
// -----------------------------------------------------------------------------
// tun_scale
// Magnitudes, common bit length, normalizing shift, squares and their sum.
// -----------------------------------------------------------------------------
module tun_scale #(
    parameter int COORD_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic                           in_vld,
    input  logic signed [2*COORD_BITS+2:0] n_x,
    input  logic signed [2*COORD_BITS+2:0] n_y,
    input  logic signed [2*COORD_BITS+2:0] n_z,
    output logic                           out_vld,
    output logic [tun_pkg::SUM_BITS-1:0]   sum,
    output tun_pkg::umag_t                 u_x,
    output tun_pkg::umag_t                 u_y,
    output tun_pkg::umag_t                 u_z,
    output tun_pkg::sgn_t                  sgn
);

    localparam int CW  = 2 * COORD_BITS + 3;
    localparam int MW  = CW - 1;
    localparam int LW  = $clog2(MW + 1);
    localparam int NT  = tun_pkg::NORM_TOP;
    localparam int XW  = (MW > NT) ? MW : NT;
    localparam int SQW = 2 * NT;
    localparam int SB  = tun_pkg::SUM_BITS;

    function automatic logic [LW-1:0] bit_len(input logic [MW-1:0] v);
        logic [LW-1:0] n;
        n = '0;
        for (int i = 0; i < MW; i++)
        begin
            if (v[i])
            begin
                n = LW'(i + 1);
            end
        end
        return n;
    endfunction

    // one valid bit per stage: magnitude, length, shift, square, sum
    logic [4:0] vld_reg;
    logic [MW-1:0] mag_reg [3];
    logic [MW-1:0] magl_reg [3];
    logic [LW-1:0] len_reg;
    tun_pkg::umag_t u_reg [3];
    tun_pkg::umag_t u2_reg [3];
    tun_pkg::umag_t u3_reg [3];
    logic [SQW-1:0] sq_reg [3];
    logic [SB-1:0] sum_reg;
    tun_pkg::sgn_t sgn_a_reg, sgn_b_reg, sgn_c_reg, sgn_d_reg, sgn_e_reg;
    logic signed [CW-1:0] n_in [3];
    tun_pkg::umag_t u_next [3];

    assign n_in[0] = n_x;
    assign n_in[1] = n_y;
    assign n_in[2] = n_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (len_reg > LW'(NT))
            begin
                u_next[i] = NT'(XW'(magl_reg[i]) >> (len_reg - LW'(NT)));
            end
            else
            begin
                u_next[i] = NT'(XW'(magl_reg[i]) << (LW'(NT) - len_reg));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[3:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sgn_a_reg.neg[i] <= n_in[i][CW-1];
                mag_reg[i] <= n_in[i][CW-1] ? MW'(-n_in[i]) : MW'(n_in[i]);
            end
            sgn_a_reg.deg <= 1'b0;
            // bit length of the OR equals that of the largest magnitude
            len_reg <= bit_len(mag_reg[0] | mag_reg[1] | mag_reg[2]);
            magl_reg <= mag_reg;
            sgn_b_reg.neg <= sgn_a_reg.neg;
            sgn_b_reg.deg <= ((mag_reg[0] | mag_reg[1] | mag_reg[2]) == '0);
            u_reg <= u_next;
            sgn_c_reg <= sgn_b_reg;
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= u_reg[i] * u_reg[i];
            end
            u2_reg <= u_reg;
            sgn_d_reg <= sgn_c_reg;
            sum_reg <= SB'(sq_reg[0]) + SB'(sq_reg[1]) + SB'(sq_reg[2]);
            u3_reg <= u2_reg;
            sgn_e_reg <= sgn_d_reg;
        end
    end

    assign out_vld = vld_reg[4];
    assign sum     = sum_reg;
    assign u_x     = u3_reg[0];
    assign u_y     = u3_reg[1];
    assign u_z     = u3_reg[2];
    assign sgn     = sgn_e_reg;

endmodule

[design/tun_isqrt.sv]
// -----------------------------------------------------------------------------
// tun_isqrt
// Pipelined integer square root, one root bit per stage.
// -----------------------------------------------------------------------------
module tun_isqrt #(
    parameter int SW = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_vld,
    input  logic [tun_pkg::SUM_BITS-1:0]  sum,
    input  logic [SW-1:0]                 in_side,
    output logic                          out_vld,
    output logic [tun_pkg::ROOT_BITS-1:0] root,
    output logic [SW-1:0]                 out_side
);

    localparam int RB = tun_pkg::ROOT_BITS;
    localparam int SB = tun_pkg::SUM_BITS;

    logic [SB-1:0] rem_in [RB];
    logic [SB-1:0] rem_reg [RB];
    logic [RB-1:0] root_in [RB];
    logic [RB-1:0] root_reg [RB];
    logic [SW-1:0] side_in [RB];
    logic [SW-1:0] side_reg [RB];
    logic          vld_in [RB];
    logic          vld_reg [RB];

    always_comb
    begin
        rem_in[0]  = sum;
        root_in[0] = '0;
        side_in[0] = in_side;
        vld_in[0]  = in_vld;
        for (int g = 1; g < RB; g++)
        begin
            rem_in[g]  = rem_reg[g-1];
            root_in[g] = root_reg[g-1];
            side_in[g] = side_reg[g-1];
            vld_in[g]  = vld_reg[g-1];
        end
    end

    for (genvar g = 0; g < RB; g++)
    begin : g_stage
        localparam int K = RB - 1 - g;
        logic [SB-1:0] trial;
        logic          ge;

        // root bits sit above K, so the two terms never overlap
        assign trial = (SB'(root_in[g]) << (K + 1)) | (SB'(1) << (2 * K));
        assign ge    = (rem_in[g] >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[g] <= vld_in[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[g]  <= ge ? rem_in[g] - trial : rem_in[g];
                root_reg[g] <= root_in[g] | (ge ? (RB'(1) << K) : '0);
                side_reg[g] <= side_in[g];
            end
        end
    end

    assign out_vld  = vld_reg[RB-1];
    assign root     = root_reg[RB-1];
    assign out_side = side_reg[RB-1];

endmodule

[design/tun_div.sv]
// -----------------------------------------------------------------------------
// tun_div
// Rounded division of the three magnitudes by the root, restoring,
// one quotient bit per stage for all three lanes.
// -----------------------------------------------------------------------------
module tun_div #(
    parameter int FRAC_BITS = 14
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_vld,
    input  tun_pkg::umag_t                u_x,
    input  tun_pkg::umag_t                u_y,
    input  tun_pkg::umag_t                u_z,
    input  logic [tun_pkg::ROOT_BITS-1:0] root,
    input  tun_pkg::sgn_t                 in_sgn,
    output logic                          out_vld,
    output logic [FRAC_BITS:0]            q_x,
    output logic [FRAC_BITS:0]            q_y,
    output logic [FRAC_BITS:0]            q_z,
    output tun_pkg::sgn_t                 out_sgn
);

    localparam int NT = tun_pkg::NORM_TOP;
    localparam int RB = tun_pkg::ROOT_BITS;
    localparam int NW = NT + FRAC_BITS + 1;
    localparam int QB = FRAC_BITS + 1;

    tun_pkg::umag_t u_in [3];
    logic [NW-1:0] num_reg [3];
    logic [RB-1:0] div_reg;
    tun_pkg::sgn_t sgn_p_reg;
    logic          vld_p_reg;

    logic [NW-1:0] rem_in [QB][3];
    logic [NW-1:0] rem_reg [QB][3];
    logic [QB-1:0] q_in [QB][3];
    logic [QB-1:0] q_reg [QB][3];
    logic [RB-1:0] d_in [QB];
    logic [RB-1:0] d_reg [QB];
    tun_pkg::sgn_t sgn_in [QB];
    tun_pkg::sgn_t sgn_reg [QB];
    logic          vld_in [QB];
    logic          vld_reg [QB];

    assign u_in[0] = u_x;
    assign u_in[1] = u_y;
    assign u_in[2] = u_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_p_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_p_reg <= in_vld;
        end
    end

    // numerator carries half the divisor for round half away from zero
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i] <= (NW'(u_in[i]) << FRAC_BITS) + NW'(root >> 1);
            end
            div_reg   <= root;
            sgn_p_reg <= in_sgn;
        end
    end

    always_comb
    begin
        rem_in[0] = num_reg;
        for (int i = 0; i < 3; i++)
        begin
            q_in[0][i] = '0;
        end
        d_in[0]   = div_reg;
        sgn_in[0] = sgn_p_reg;
        vld_in[0] = vld_p_reg;
        for (int g = 1; g < QB; g++)
        begin
            rem_in[g] = rem_reg[g-1];
            q_in[g]   = q_reg[g-1];
            d_in[g]   = d_reg[g-1];
            sgn_in[g] = sgn_reg[g-1];
            vld_in[g] = vld_reg[g-1];
        end
    end

    for (genvar g = 0; g < QB; g++)
    begin : g_stage
        localparam int K = QB - 1 - g;
        logic [NW-1:0] dsh;

        assign dsh = NW'(d_in[g]) << K;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[g] <= vld_in[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (rem_in[g][i] >= dsh)
                    begin
                        rem_reg[g][i] <= rem_in[g][i] - dsh;
                        q_reg[g][i]   <= q_in[g][i] | (QB'(1) << K);
                    end
                    else
                    begin
                        rem_reg[g][i] <= rem_in[g][i];
                        q_reg[g][i]   <= q_in[g][i];
                    end
                end
                d_reg[g]   <= d_in[g];
                sgn_reg[g] <= sgn_in[g];
            end
        end
    end

    assign out_vld = vld_reg[QB-1];
    assign q_x     = q_reg[QB-1][0];
    assign q_y     = q_reg[QB-1][1];
    assign q_z     = q_reg[QB-1][2];
    assign out_sgn = sgn_reg[QB-1];

endmodule

[design/triangle_unit_normal.sv]
// -----------------------------------------------------------------------------
// triangle_unit_normal
// Unit face normal of a triangle from its three integer corners.
// -----------------------------------------------------------------------------
// Takes one triangle per clock, unless the output holds, and returns one
// normal per triangle, in order. The pipe has three stages for the edges and
// cross product, five for normalizing and summing the squares, one stage per
// root bit of the 31-bit square root, and one prep stage plus one stage per
// quotient bit of the three-lane divider, then the output register.
// The whole pipe holds while a finished word waits at the output; triangles
// whose corners are collinear or coincident give a zero normal with the
// degenerate flag set in m_tuser.
`include "triangle_unit_normal_defines.svh"

module triangle_unit_normal #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    input  logic [((9*COORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // norm_x, norm_y, norm_z
    output logic [((3*(FRAC_BITS+2)+7)/8)*8-1:0] m_tdata,
    // degenerate
    output logic m_tuser
);

    localparam int OW  = FRAC_BITS + 2;
    localparam int ODW = ((3 * OW + 7) / 8) * 8;
    localparam int CW  = 2 * COORD_BITS + 3;
    localparam int SW  = 3 * tun_pkg::NORM_TOP + $bits(tun_pkg::sgn_t);

    logic adv;
    logic cr_vld, sc_vld, sq_vld, div_vld;
    logic signed [CW-1:0] n_x, n_y, n_z;
    logic [tun_pkg::SUM_BITS-1:0] sum;
    tun_pkg::umag_t sc_ux, sc_uy, sc_uz;
    tun_pkg::umag_t sq_ux, sq_uy, sq_uz;
    tun_pkg::sgn_t sc_sgn, sq_sgn, div_sgn;
    logic [tun_pkg::ROOT_BITS-1:0] root;
    logic [FRAC_BITS:0] q_x, q_y, q_z;

    logic out_vld_reg;
    logic deg_reg;
    logic signed [OW-1:0] norm_x_reg, norm_y_reg, norm_z_reg;

    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;

    tun_cross #(
        .COORD_BITS(COORD_BITS)
    ) u_cross (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .in_vld (s_tvalid),
        .pts    (s_tdata[9*COORD_BITS-1:0]),
        .out_vld(cr_vld),
        .n_x    (n_x),
        .n_y    (n_y),
        .n_z    (n_z)
    );

    tun_scale #(
        .COORD_BITS(COORD_BITS)
    ) u_scale (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .in_vld (cr_vld),
        .n_x    (n_x),
        .n_y    (n_y),
        .n_z    (n_z),
        .out_vld(sc_vld),
        .sum    (sum),
        .u_x    (sc_ux),
        .u_y    (sc_uy),
        .u_z    (sc_uz),
        .sgn    (sc_sgn)
    );

    tun_isqrt #(
        .SW(SW)
    ) u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (sc_vld),
        .sum     (sum),
        .in_side ({sc_uz, sc_uy, sc_ux, sc_sgn}),
        .out_vld (sq_vld),
        .root    (root),
        .out_side({sq_uz, sq_uy, sq_ux, sq_sgn})
    );

    tun_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .in_vld (sq_vld),
        .u_x    (sq_ux),
        .u_y    (sq_uy),
        .u_z    (sq_uz),
        .root   (root),
        .in_sgn (sq_sgn),
        .out_vld(div_vld),
        .q_x    (q_x),
        .q_y    (q_y),
        .q_z    (q_z),
        .out_sgn(div_sgn)
    );

    function automatic logic signed [OW-1:0] apply_sign(
        input logic [FRAC_BITS:0] q,
        input logic               neg,
        input logic               deg
    );
        logic signed [OW-1:0] v;
        v = neg ? OW'(0) - OW'(q) : OW'(q);
        return deg ? '0 : v;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= div_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            norm_x_reg <= apply_sign(q_x, div_sgn.neg[0], div_sgn.deg);
            norm_y_reg <= apply_sign(q_y, div_sgn.neg[1], div_sgn.deg);
            norm_z_reg <= apply_sign(q_z, div_sgn.neg[2], div_sgn.deg);
            deg_reg    <= div_sgn.deg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = ODW'({norm_z_reg, norm_y_reg, norm_x_reg});
    assign m_tuser  = deg_reg;

    // zero normal must come out as a zero word
    `TUN_ASSERT_NEVER(a_deg_zero, out_vld_reg && deg_reg && (norm_x_reg != '0 || norm_y_reg != '0 || norm_z_reg != '0))
    // unit length bounds every quotient by one
    `TUN_ASSERT(a_q_bound, div_vld && !div_sgn.deg |-> q_x <= ((FRAC_BITS+1)'(1) << FRAC_BITS) && q_y <= ((FRAC_BITS+1)'(1) << FRAC_BITS) && q_z <= ((FRAC_BITS+1)'(1) << FRAC_BITS))
    // the largest component is at least 1/sqrt(3), so above one half
    `TUN_ASSERT(a_q_large, div_vld && !div_sgn.deg |-> (q_x[FRAC_BITS] || q_x[FRAC_BITS-1] || q_y[FRAC_BITS] || q_y[FRAC_BITS-1] || q_z[FRAC_BITS] || q_z[FRAC_BITS-1]))

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Tests the triangle unit normal pipeline. Triangles go in on the slave
// stream and normals are checked, field by field and in order, against a
// normal computed here from the corner coordinates.
// ----------------------------------------------------------------------------
module tb;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 14;
    localparam int OUT_BITS   = FRAC_BITS + 2;
    localparam int LATENCY    = FRAC_BITS + 42;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [COORD_BITS-1:0] p[9];  // a_x a_y a_z b_x b_y b_z c_x c_y c_z
    } tri_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] x;
        logic [OUT_BITS-1:0] y;
        logic [OUT_BITS-1:0] z;
        logic                deg;
    } normal_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [143:0] s_tdata;  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    logic m_tvalid;
    logic m_tready;
    logic [47:0] m_tdata;   // norm_x, norm_y, norm_z
    logic m_tuser;          // degenerate

    normal_t normals_due[$];
    int      n_errors;
    int      cycle_cnt;
    int      hold_len;
    int      stall_mode;

    triangle_unit_normal #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic normal_t face_normal(input tri_t t);
        longint e1[3];
        longint e2[3];
        longint n[3];
        longint unsigned m[3];
        longint unsigned u[3];
        longint unsigned sq;
        longint unsigned r;
        longint unsigned q[3];
        logic [OUT_BITS-1:0] o[3];
        int len;
        int sh;
        normal_t res;
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = longint'(t.p[3+i]) - longint'(t.p[i]);
            e2[i] = longint'(t.p[6+i]) - longint'(t.p[i]);
        end
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        len = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = (n[i] < 0) ? longint'(-n[i]) : n[i];
            for (int b = 0; b < 64; b++)
                if (m[i][b] && b + 1 > len)
                    len = b + 1;
        end
        res = '0;
        if (len == 0)
        begin
            res.deg = 1'b1;
            return res;
        end
        // bring the largest magnitude into [2^29, 2^30)
        sh = len - tun_pkg::NORM_TOP;
        sq = 0;
        for (int i = 0; i < 3; i++)
        begin
            u[i] = (sh > 0) ? (m[i] >> sh) : (m[i] << (-sh));
            sq = sq + u[i] * u[i];
        end
        r = int_sqrt(sq);
        for (int i = 0; i < 3; i++)
        begin
            q[i] = ((u[i] << FRAC_BITS) + (r >> 1)) / r;
            o[i] = (n[i] < 0) ? -q[i][OUT_BITS-1:0] : q[i][OUT_BITS-1:0];
        end
        res.x = o[0];
        res.y = o[1];
        res.z = o[2];
        return res;
    endfunction

    // one triangle; gap > 0 drops tvalid afterwards, gap giving the length of the pause
    task automatic send_tri(input tri_t t, input int gap);
        logic [143:0] d;
        for (int i = 0; i < 9; i++)
            d[i*16 +: 16] = t.p[i];
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do
            @(posedge clk);
        while (!s_tready);
        normals_due.insert(normals_due.size(), face_normal(t));
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic tri_t rand_tri(input int span);
        tri_t t;
        int base;
        base = $urandom_range(65535);
        for (int i = 0; i < 9; i++)
            if (span >= 65535)
                t.p[i] = 16'($urandom);
            else
                t.p[i] = 16'(base + $urandom_range(span));
        return t;
    endfunction

    // burst length counts down; a gap may come at the end of each burst
    int burst_left;
    function automatic int next_gap();
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(20);
        return ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
    endfunction

    task automatic test_extremes();
        tri_t t;
        logic signed [15:0] ext[4];
        ext = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
        for (int k = 0; k < 14; k++)
        begin
            for (int i = 0; i < 9; i++)
                t.p[i] = ext[(i * (k + 1) + k / 4) % 4];
            send_tri(t, k % 3);
        end
        // largest edges in orthogonal directions
        t.p = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
                16'sh8000, 16'sh7fff, 16'sh8000};
        send_tri(t, 0);
        t.p = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff,
                16'sh7fff, 16'sh7fff, 16'sh8000};
        send_tri(t, 0);
        // unit right triangle, smallest nonzero normal
        t.p = '{16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0};
        send_tri(t, 1);
    endtask

    task automatic test_degenerate();
        tri_t t;
        t.p = '{default: 16'sd0};
        send_tri(t, 0);
        t.p = '{default: 16'sh8000};
        send_tri(t, 0);
        // collinear
        t.p = '{16'sd1, 16'sd2, 16'sd3, 16'sd3, 16'sd6, 16'sd9, -16'sd1, -16'sd2, -16'sd3};
        send_tri(t, 2);
        t.p = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sd0, 16'sd0, 16'sd0,
                16'sh7fff, 16'sh7fff, 16'sh7fff};
        send_tri(t, 0);
        // two corners coincident
        t.p = '{16'sd5, -16'sd7, 16'sd100, 16'sd5, -16'sd7, 16'sd100, 16'sd9, 16'sd1, 16'sd2};
        send_tri(t, 0);
    endtask

    task automatic test_random(input int n_items, input int mode);
        tri_t t;
        int k;
        int sel;
        stall_mode = mode;
        for (int i = 0; i < n_items; i++)
        begin
            sel = $urandom_range(9);
            if (sel < 5)
                t = rand_tri(65535);
            else if (sel < 8)
                t = rand_tri(1 << $urandom_range(1, 12));
            else
            begin
                // mostly collinear: c = a + k * (b - a)
                t = rand_tri(200);
                k = $urandom_range(0, 4) - 2;
                for (int j = 0; j < 3; j++)
                    t.p[6+j] = 16'(t.p[j] + k * (t.p[3+j] - t.p[j]));
            end
            send_tri(t, next_gap());
        end
    endtask

    task automatic test_backpressure();
        tri_t t;
        hold_len = 400;
        for (int i = 0; i < 150; i++)
        begin
            t = rand_tri(65535);
            send_tri(t, 0);
        end
    endtask

    // receiver: long hold-off on request, otherwise always ready or a stall pattern, by stall_mode
    int pat_cnt;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            pat_cnt  <= 0;
        end
        else
        begin
            pat_cnt <= pat_cnt + 1;
            if (hold_len > 0)
            begin
                m_tready <= 1'b0;
                hold_len--;
            end
            else if (stall_mode == 0)
                m_tready <= 1'b1;
            else if (stall_mode == 1)
                m_tready <= ($urandom_range(3) != 0);
            else
                m_tready <= (pat_cnt % 7 < 4) || (pat_cnt % 53 > 40);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (normals_due.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: unexpected word x=%h y=%h z=%h deg=%b",
                             m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tuser);
            end
            else
            begin
                normal_t e;
                e = normals_due.pop_front();
                if (m_tdata[15:0] !== e.x || m_tdata[31:16] !== e.y ||
                    m_tdata[47:32] !== e.z || m_tuser !== e.deg)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: expected x=%h y=%h z=%h deg=%b, got x=%h y=%h z=%h deg=%b",
                                 e.x, e.y, e.z, e.deg, m_tdata[15:0], m_tdata[31:16],
                                 m_tdata[47:32], m_tuser);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        n_errors   = 0;
        cycle_cnt  = 0;
        hold_len   = 0;
        stall_mode = 0;
        burst_left = 0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_degenerate();
        test_random(500, 0);
        test_random(450, 1);
        test_backpressure();
        test_random(450, 2);
        s_tvalid <= 1'b0;

        while (normals_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
